@@ design/cesi_pkg.sv @@
// ----------------------------------------------------------------------------
// C escape sequence interpreter: shared definitions
// Character codes, parse modes and the queue entry that moves decoded
// results from the front stage to the back stage.
// ----------------------------------------------------------------------------
package cesi_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_QUOTE  = 2'd1;
  localparam logic [1:0] MODE_ESCAPE = 2'd2;
  localparam logic [1:0] MODE_DIGITS = 2'd3;

  // Digits taken before the one that completes a run.
  localparam logic [1:0] RUN_LAST = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Results caused by one input byte: one or two bytes.
  typedef struct packed {
    logic       two;
    logic [7:0] first;
    logic [7:0] second;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ design/cesi_front.sv @@
// ----------------------------------------------------------------------------
// C escape sequence interpreter: front stage
// Accepts one string byte per cycle unless the queue is full, tracks the parse
// mode and digit run, and pushes any decoded results of a byte as one entry.
// ----------------------------------------------------------------------------
module cesi_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  cesi_pkg::qstat_t     qstat,
  output logic                 push,
  output cesi_pkg::entry_t     push_entry
);

  logic [1:0] mode, mode_next;
  logic [7:0] digit_value, digit_value_next;
  logic [1:0] digit_count, digit_count_next;

  logic       accept;
  logic       is_digit;
  logic [7:0] digit;
  logic [7:0] acc;
  logic [1:0] cnt;
  logic [7:0] r0, r1;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign is_digit = (in_byte >= cesi_pkg::CH_ZERO) && (in_byte <= cesi_pkg::CH_NINE);
  assign digit    = in_byte - cesi_pkg::CH_ZERO;
  assign acc      = {digit_value[4:0], 3'b000} + digit;

  always_comb begin
    cnt              = 2'd0;
    r0               = in_byte;
    r1               = in_byte;
    mode_next        = mode;
    digit_value_next = digit_value;
    digit_count_next = digit_count;
    unique case (mode)
      cesi_pkg::MODE_NORMAL: begin
        if (in_byte == cesi_pkg::CH_NUL) begin
          cnt = 2'd1;
        end else if (in_byte == cesi_pkg::CH_QUOTE) begin
          cnt       = 2'd1;
          mode_next = cesi_pkg::MODE_QUOTE;
        end else if (in_byte == cesi_pkg::CH_BSLASH) begin
          mode_next = cesi_pkg::MODE_ESCAPE;
        end else begin
          cnt = 2'd1;
        end
      end
      cesi_pkg::MODE_QUOTE: begin
        cnt = 2'd1;
        if (in_byte == cesi_pkg::CH_NUL || in_byte == cesi_pkg::CH_QUOTE) begin
          mode_next = cesi_pkg::MODE_NORMAL;
        end
      end
      cesi_pkg::MODE_ESCAPE: begin
        mode_next = cesi_pkg::MODE_NORMAL;
        if (in_byte == cesi_pkg::CH_BSLASH) begin
          cnt = 2'd1;
        end else if (in_byte == cesi_pkg::CH_N) begin
          cnt = 2'd1;
          r0  = cesi_pkg::CH_LF;
        end else if (in_byte == cesi_pkg::CH_T) begin
          cnt = 2'd1;
          r0  = cesi_pkg::CH_TAB;
        end else if (is_digit) begin
          digit_value_next = digit;
          digit_count_next = 2'd1;
          mode_next        = cesi_pkg::MODE_DIGITS;
        end else begin
          // Unknown escape (terminator included): backslash, then the byte
          // as in normal mode, where a quote opens a quoted span.
          cnt = 2'd2;
          r0  = cesi_pkg::CH_BSLASH;
          if (in_byte == cesi_pkg::CH_QUOTE) begin
            mode_next = cesi_pkg::MODE_QUOTE;
          end
        end
      end
      cesi_pkg::MODE_DIGITS: begin
        if (is_digit) begin
          if (digit_count == cesi_pkg::RUN_LAST) begin
            cnt              = 2'd1;
            r0               = acc;
            digit_value_next = 8'd0;
            digit_count_next = 2'd0;
            mode_next        = cesi_pkg::MODE_NORMAL;
          end else begin
            digit_value_next = acc;
            digit_count_next = digit_count + 2'd1;
          end
        end else begin
          // Run cut short: the value goes out first, then the byte is
          // handled as in normal mode.
          r0               = digit_value;
          digit_value_next = 8'd0;
          digit_count_next = 2'd0;
          mode_next        = cesi_pkg::MODE_NORMAL;
          if (in_byte == cesi_pkg::CH_BSLASH) begin
            cnt       = 2'd1;
            mode_next = cesi_pkg::MODE_ESCAPE;
          end else begin
            cnt = 2'd2;
            if (in_byte == cesi_pkg::CH_QUOTE) begin
              mode_next = cesi_pkg::MODE_QUOTE;
            end
          end
        end
      end
      default: begin
        mode_next = cesi_pkg::MODE_NORMAL;
      end
    endcase
    // The terminator always returns the machine to its reset state.
    if (in_byte == cesi_pkg::CH_NUL) begin
      mode_next        = cesi_pkg::MODE_NORMAL;
      digit_value_next = 8'd0;
      digit_count_next = 2'd0;
    end
  end

  assign push              = accept && (cnt != 2'd0);
  assign push_entry.two    = (cnt == 2'd2);
  assign push_entry.first  = r0;
  assign push_entry.second = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= cesi_pkg::MODE_NORMAL;
      digit_value <= 8'd0;
      digit_count <= 2'd0;
    end else if (accept) begin
      mode        <= mode_next;
      digit_value <= digit_value_next;
      digit_count <= digit_count_next;
    end
  end

endmodule

@@ design/cesi_queue.sv @@
// ----------------------------------------------------------------------------
// C escape sequence interpreter: entry queue
// A short first-in first-out queue of result entries between the front
// and back stages.
// ----------------------------------------------------------------------------
module cesi_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cesi_pkg::entry_t     push_entry,
  input  logic                 pop,
  output cesi_pkg::entry_t     head,
  output cesi_pkg::qstat_t     qstat
);

  cesi_pkg::entry_t mem [cesi_pkg::QUEUE_DEPTH];

  logic [cesi_pkg::QPTR_W-1:0] wr_ptr;
  logic [cesi_pkg::QPTR_W-1:0] rd_ptr;
  logic [cesi_pkg::QPTR_W:0]   fill;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (fill == (cesi_pkg::QPTR_W + 1)'(cesi_pkg::QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ design/cesi_back.sv @@
// ----------------------------------------------------------------------------
// C escape sequence interpreter: back stage
// Takes entries from the queue and sends their results out one per cycle
// through an output register while out_ready is high.
// ----------------------------------------------------------------------------
module cesi_back (
  input  logic                 clk,
  input  logic                 rst,
  input  cesi_pkg::entry_t     head,
  input  cesi_pkg::qstat_t     qstat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 end_of_string,
  output logic                 last_in_run
);

  logic       on_second;
  logic       load;
  logic       split;
  logic [7:0] pick;

  assign load  = !out_valid || out_ready;
  // A two-result entry stays at the head until its second byte is loaded.
  assign split = head.two && !on_second;
  assign pop   = load && !qstat.empty && !split;
  assign pick  = on_second ? head.second : head.first;

  always_ff @(posedge clk) begin
    if (load && !qstat.empty) begin
      out_byte      <= pick;
      end_of_string <= (pick == cesi_pkg::CH_NUL);
      last_in_run   <= !split;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      on_second <= 1'b0;
    end else if (load) begin
      out_valid <= !qstat.empty;
      if (!qstat.empty) begin
        on_second <= split;
      end
    end
  end

endmodule

@@ design/c_escape_sequence_interpreter_unit.sv @@
// ----------------------------------------------------------------------------
// C escape sequence interpreter
// Decodes C string escapes from a byte stream into a decoded byte stream.
// ----------------------------------------------------------------------------
// The block takes one string byte per clock cycle and produces zero, one or
// two decoded bytes for it; last_in_run marks the final byte caused by an
// input and end_of_string marks a zero byte. Results leave at one per cycle
// from the output register while out_ready is high, so a byte that decodes
// to two results leaves as two output bytes. A four-entry queue sits between
// the parsing stage and the output stage; input is held off only when that
// queue is full. A result is held in the queue, then in the output register.
module c_escape_sequence_interpreter_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       end_of_string,
  output logic       last_in_run
);

  cesi_pkg::qstat_t qstat;
  cesi_pkg::entry_t push_entry;
  cesi_pkg::entry_t head;
  logic             push;
  logic             pop;

  cesi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  cesi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  cesi_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .end_of_string (end_of_string),
    .last_in_run   (last_in_run)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full))
    else $error("request pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("queue popped while empty");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_in_run) |=> (out_valid && last_in_run))
    else $error("second result of a request did not follow directly");

  a_eos_matches_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_of_string == (out_byte == cesi_pkg::CH_NUL)))
    else $error("end_of_string disagrees with the output byte");

endmodule
